// ----- hw/rtl/uvd_pkg.sv -----
// Shared types, status codes and constants for the UTF-8 validating decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package uvd_pkg;

   // Longest legacy sequence the decoder handles by default
   localparam int MAX_SEQUENCE_BYTES_DEFAULT = 6;

   // Byte masks and value limits
   localparam logic [7:0]  CONT_MASK      = 8'hC0;
   localparam logic [7:0]  CONT_TAG       = 8'h80;
   localparam logic [7:0]  PAYLOAD_MASK   = 8'h3F;
   localparam logic [30:0] SURROGATE_LO   = 31'h0000D800;
   localparam logic [30:0] SURROGATE_HI   = 31'h0000DFFF;
   localparam logic [30:0] NONCHAR_LO     = 31'h0000FDD0;
   localparam logic [30:0] NONCHAR_HI     = 31'h0000FDEF;
   localparam logic [30:0] NONCHAR_TAIL   = 31'h0000FFFE;
   localparam logic [30:0] PLANE_LIMIT    = 31'h00110000;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_START = 3'd1,
      ST_BAD_CONT  = 3'd2,
      ST_TRUNCATED = 3'd3,
      ST_OVERLONG  = 3'd4,
      ST_SURROGATE = 3'd5,
      ST_NONCHAR   = 3'd6
   } uvd_status_type;

   // One input byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } uvd_item_type;

   // One decoded result
   typedef struct packed {
      logic [30:0]    code_point;
      logic [2:0]     char_length;
      uvd_status_type status;
   } uvd_result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/uvd_in_stage.sv -----
// Input register of the decoder: holds one accepted byte until the core takes it.
// Depends on uvd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uvd_in_stage
   import uvd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // data_byte[7:0]
   input  wire logic         req_tlast,   // last_byte
   input  wire logic         take,
   output logic              item_valid,
   output uvd_item_type      item
);

   logic         valid_ff, valid_in;
   uvd_item_type item_ff;

   // Free when empty or when the held byte leaves this cycle
   assign req_tready = !valid_ff || take;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload captured on each accepted transaction
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.data_byte <= req_tdata;
         item_ff.last_byte <= req_tlast;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/uvd_decode.sv -----
// Decoder core: sequence state registers and the single-pass byte step logic.
// Depends on uvd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uvd_decode
   import uvd_pkg::*;
#(
   parameter int MAX_SEQUENCE_BYTES = MAX_SEQUENCE_BYTES_DEFAULT
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire uvd_item_type item,
   input  wire logic         advance,
   output logic              has_result,
   output uvd_result_type    result
);

   localparam logic [2:0] MAX_LEN = 3'(MAX_SEQUENCE_BYTES);

   logic [2:0]  remaining_ff, remaining_in;
   logic [2:0]  seq_len_ff, seq_len_in;
   logic [30:0] acc_ff, acc_in;

   logic [7:0]  b;
   logic        last;
   logic [3:0]  ones;
   logic [2:0]  start_len;
   logic [30:0] acc_next;
   logic [30:0] chk_value;
   logic [2:0]  min_len;
   uvd_status_type chk_status;

   assign b    = item.data_byte;
   assign last = item.last_byte;

   // Run of leading ones in the byte
   always_comb begin
      if      (!b[7]) ones = 4'd0;
      else if (!b[6]) ones = 4'd1;
      else if (!b[5]) ones = 4'd2;
      else if (!b[4]) ones = 4'd3;
      else if (!b[3]) ones = 4'd4;
      else if (!b[2]) ones = 4'd5;
      else if (!b[1]) ones = 4'd6;
      else if (!b[0]) ones = 4'd7;
      else            ones = 4'd8;
   end

   assign start_len = (ones == 4'd0) ? 3'd1 : ones[2:0];
   assign acc_next  = {acc_ff[24:0], b[5:0] & PAYLOAD_MASK[5:0]};
   assign chk_value = acc_next;

   // Shortest encoding of the completed value
   always_comb begin
      if      (chk_value < 31'h00000080) min_len = 3'd1;
      else if (chk_value < 31'h00000800) min_len = 3'd2;
      else if (chk_value < 31'h00010000) min_len = 3'd3;
      else if (chk_value < 31'h00200000) min_len = 3'd4;
      else if (chk_value < 31'h04000000) min_len = 3'd5;
      else                               min_len = 3'd6;
   end

   // Completion checks: overlong, then surrogate, then noncharacter
   always_comb begin
      if (min_len < seq_len_ff) begin
         chk_status = ST_OVERLONG;
      end else if (chk_value >= SURROGATE_LO && chk_value <= SURROGATE_HI) begin
         chk_status = ST_SURROGATE;
      end else if (chk_value >= NONCHAR_LO && chk_value <= NONCHAR_HI) begin
         chk_status = ST_NONCHAR;
      end else if ((chk_value & NONCHAR_TAIL) == NONCHAR_TAIL && chk_value < PLANE_LIMIT) begin
         chk_status = ST_NONCHAR;
      end else begin
         chk_status = ST_OK;
      end
   end

   // Byte step: next state and the result it causes
   always_comb begin
      remaining_in       = remaining_ff;
      seq_len_in         = seq_len_ff;
      acc_in             = acc_ff;
      has_result         = 1'b0;
      result.code_point  = '0;
      result.char_length = '0;
      result.status      = ST_OK;
      if (remaining_ff == 3'd0) begin
         if (ones == 4'd1 || ones > 4'd6 || start_len > MAX_LEN) begin
            // Stray continuation, FE/FF, or a sequence too long
            has_result    = 1'b1;
            result.status = ST_BAD_START;
         end else if (start_len == 3'd1) begin
            // Plain ASCII always passes the checks
            has_result         = 1'b1;
            result.code_point  = {24'd0, b[6:0]};
            result.char_length = 3'd1;
         end else if (last) begin
            has_result         = 1'b1;
            result.char_length = start_len;
            result.status      = ST_TRUNCATED;
         end else begin
            acc_in       = {23'd0, b & (8'hFF >> (ones + 4'd1))};
            seq_len_in   = start_len;
            remaining_in = start_len - 3'd1;
         end
      end else begin
         if (last && remaining_ff > 3'd1) begin
            has_result         = 1'b1;
            result.char_length = seq_len_ff;
            result.status      = ST_TRUNCATED;
         end else if ((b & CONT_MASK) != CONT_TAG) begin
            has_result         = 1'b1;
            result.char_length = seq_len_ff;
            result.status      = ST_BAD_CONT;
         end else if (remaining_ff == 3'd1) begin
            has_result         = 1'b1;
            result.code_point  = (chk_status == ST_OK) ? chk_value : 31'd0;
            result.char_length = seq_len_ff;
            result.status      = chk_status;
         end else begin
            acc_in       = acc_next;
            remaining_in = remaining_ff - 3'd1;
         end
      end
      // Any result returns the decoder to idle
      if (has_result) begin
         remaining_in = 3'd0;
         seq_len_in   = 3'd0;
         acc_in       = 31'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= 3'd0;
         seq_len_ff   <= 3'd0;
         acc_ff       <= 31'd0;
      end else if (advance) begin
         remaining_ff <= remaining_in;
         seq_len_ff   <= seq_len_in;
         acc_ff       <= acc_in;
      end
   end

`ifndef ASSERT_OFF
   // A byte marked last always leaves the decoder idle
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && last |=> remaining_ff == 3'd0)
      else $error("decoder not idle after last byte");

   // Owed bytes never reach the sequence length
   a_remaining_bound: assert property (@(posedge clock) disable iff (reset)
      remaining_ff != 3'd0 |-> remaining_ff < seq_len_ff && seq_len_ff <= MAX_LEN)
      else $error("owed byte count out of range");

   // Idle state carries no partial sequence
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      remaining_ff == 3'd0 |-> seq_len_ff == 3'd0 && acc_ff == 31'd0)
      else $error("idle decoder holds a partial sequence");

   // Error results never carry a code point
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      has_result && result.status != ST_OK |-> result.code_point == 31'd0)
      else $error("error result with nonzero code point");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/uvd_out_stage.sv -----
// Result register of the decoder: holds one result until the consumer takes it.
// Depends on uvd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uvd_out_stage
   import uvd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire uvd_result_type result,
   output logic                free,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output logic [39:0]         rsp_tdata,  // code_point[30:0], char_length[33:31], zero fill
   output logic [2:0]          rsp_tuser   // status[2:0]
);

   logic           valid_ff, valid_in;
   uvd_result_type result_ff;

   // Room for a new result when empty or when the held one is taken now
   assign free     = !valid_ff || rsp_tready;
   assign valid_in = push || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, result_ff.char_length, result_ff.code_point};
   assign rsp_tuser  = result_ff.status;

endmodule

`default_nettype wire

// ----- hw/rtl/utf8_validating_decoder_unit.sv -----
// Top level of the UTF-8 validating decoder: input register, decode core, result register.
// Depends on uvd_pkg, uvd_in_stage, uvd_decode and uvd_out_stage.
`timescale 1ns / 1ps
`default_nettype none

// Decodes legacy UTF-8 (1 to MAX_SEQUENCE_BYTES bytes per character) one byte per
// transaction on the req_ stream, tlast marking the buffer's final byte. Each completed
// sequence or detected error gives one rsp_ transaction with the code point and length
// in tdata and the status in tuser; start and intermediate bytes of a good sequence give
// none. The block accepts one byte every cycle while req_tready is high; each byte passes
// from the input register through the combinational decode step, and its result, if any,
// is held in the result register and presented on rsp_ until taken. Backpressure on
// rsp_ stalls req_ only once both registers are full. No initialization pass is needed
// after reset.
module utf8_validating_decoder_unit
   import uvd_pkg::*;
#(
   parameter int MAX_SEQUENCE_BYTES = MAX_SEQUENCE_BYTES_DEFAULT
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte[7:0]
   input  wire logic        req_tlast,   // last_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // code_point[30:0], char_length[33:31], zero fill
   output logic [2:0]       rsp_tuser    // status[2:0]
);

   logic           item_valid;
   uvd_item_type   item;
   logic           has_result;
   uvd_result_type result;
   logic           out_free;
   logic           advance;

   // Step the core when a byte waits and its result, if any, has somewhere to go
   assign advance = item_valid && (!has_result || out_free);

   uvd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .take       (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   uvd_decode #(
      .MAX_SEQUENCE_BYTES (MAX_SEQUENCE_BYTES)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .advance    (advance),
      .has_result (has_result),
      .result     (result)
   );

   uvd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .push       (advance && has_result),
      .result     (result),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
